FILE: hdl/rsr_pkg.sv
// Shared types, constants and the sine table builder for the radial sine ripple block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package rsr_pkg;

  localparam int unsigned MAX_SIDE_DEF   = 1024;
  localparam int unsigned SINE_DEPTH_DEF = 256;  // power of two, 64..4096

  localparam int unsigned SQRT_CELLS  = 20;
  localparam int unsigned RAD_W       = 2 * SQRT_CELLS;
  localparam int unsigned ROOT_W      = SQRT_CELLS;
  localparam int unsigned REM_W       = ROOT_W + 1;
  localparam int unsigned PIPE_STAGES = SQRT_CELLS + 5;

  localparam logic [10:0] SIDE_RESET = 11'd200;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SIDE           = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y_SHIFT = 2'd2;

  localparam logic [63:0] Q30_ONE         = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30     = 64'd1686629713;
  localparam logic [23:0] TWO_OVER_PI_Q24 = 24'd10680707;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_lane_t;

  // {level for negative half, level for positive half} at quarter-wave angle x (Q2.30)
  function automatic logic [15:0] blue_pair(input logic [63:0] x);
    logic [63:0] x2, t, mag, up, un, lp, ln;
    x2 = (x * x) >> 30;
    t  = Q30_ONE;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
    mag = (x * t) >> 30;
    if (mag > Q30_ONE) begin
      mag = Q30_ONE;
    end
    up = Q30_ONE + mag;
    un = Q30_ONE - mag;
    lp = (up * 64'd255) >> 31;
    ln = (un * 64'd255) >> 31;
    if (lp > 64'd255) begin
      lp = 64'd255;
    end
    return {ln[7:0], lp[7:0]};
  endfunction

endpackage

`default_nettype wire

FILE: hdl/rsr_sqrt_cell.sv
// One digit cell of the integer square root chain: one root bit per cell.
// Depends on rsr_pkg (sqrt_lane_t, widths).
`default_nettype none

module rsr_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  rsr_pkg::sqrt_lane_t in_lane,
  output logic                out_valid,
  output rsr_pkg::sqrt_lane_t out_lane
);

  logic [rsr_pkg::REM_W+1:0] rem_ext;
  logic [rsr_pkg::REM_W+1:0] trial;
  logic [rsr_pkg::REM_W+1:0] diff;
  logic                      ge;
  rsr_pkg::sqrt_lane_t       lane_next;

  always_comb begin
    rem_ext = {in_lane.rem, in_lane.rad[rsr_pkg::RAD_W-1 -: 2]};
    trial   = {1'b0, in_lane.root, 2'b01};
    diff    = rem_ext - trial;
    ge      = (rem_ext >= trial);
    lane_next.rem  = ge ? diff[rsr_pkg::REM_W-1:0] : rem_ext[rsr_pkg::REM_W-1:0];
    lane_next.root = {in_lane.root[rsr_pkg::ROOT_W-2:0], ge};
    lane_next.rad  = {in_lane.rad[rsr_pkg::RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_lane <= lane_next;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/rsr_sine_lut.sv
// Quarter-wave sine table holding final blue levels, registered read.
// Depends on rsr_pkg (blue_pair, HALF_PI_Q30).
`default_nettype none

module rsr_sine_lut #(
  parameter  int unsigned SINE_TABLE_DEPTH = rsr_pkg::SINE_DEPTH_DEF,
  localparam int unsigned IDX_W            = $clog2(SINE_TABLE_DEPTH) + 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [IDX_W-1:0] idx,
  input  logic             neg,
  output logic [7:0]       level
);

  logic [7:0] lut_pos [SINE_TABLE_DEPTH+1];
  logic [7:0] lut_neg [SINE_TABLE_DEPTH+1];

  for (genvar i = 0; i <= SINE_TABLE_DEPTH; i++) begin : g_lut
    localparam logic [63:0] X =
      (64'(i) * rsr_pkg::HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
    localparam logic [15:0] PAIR = rsr_pkg::blue_pair(X);
    assign lut_pos[i] = PAIR[7:0];
    assign lut_neg[i] = PAIR[15:8];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      level <= neg ? lut_neg[idx] : lut_pos[idx];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/radial_sine_ripple_pixel_top.sv
// Radial sine ripple pixel generator: config registers, distance, sqrt chain, phase, table.
// Depends on rsr_pkg, rsr_sqrt_cell, rsr_sine_lut.
//
//   channel  | direction | handshake              | payload
//   pixel    | in        | pixel_valid/pixel_stall | pixel_x, pixel_y
//   blue     | out       | blue_valid/blue_stall   | blue_level
//   config   | in        | APB psel/penable/pready | paddr, pwdata, prdata
//
// One pixel per clock unless blue_stall holds it; stages: abs diff, squares, 20 sqrt cells, phase
// multiply, table index, table read. The sqrt cell chain sets the latency.
// Reset clears valid bits and loads side 200, shifts 0.
// Stalls back up stage by stage; empty stages keep filling while the output is held.
`default_nettype none

module radial_sine_ripple_pixel_top #(
  parameter int unsigned MAX_SIDE         = rsr_pkg::MAX_SIDE_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = rsr_pkg::SINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        pixel_valid,
  output logic        pixel_stall,
  input  logic [9:0]  pixel_x,
  input  logic [9:0]  pixel_y,
  output logic        blue_valid,
  input  logic        blue_stall,
  output logic [7:0]  blue_level
);

  localparam int unsigned DEPTH_LOG = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned IDX_W     = DEPTH_LOG + 1;

  // configuration
  logic [10:0] side_reg;
  logic [10:0] center_x_shift;
  logic [10:0] center_y_shift;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      side_reg       <= rsr_pkg::SIDE_RESET;
      center_x_shift <= 11'd0;
      center_y_shift <= 11'd0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        rsr_pkg::REG_SIDE:           side_reg       <= pwdata[10:0];
        rsr_pkg::REG_CENTER_X_SHIFT: center_x_shift <= pwdata[10:0];
        rsr_pkg::REG_CENTER_Y_SHIFT: center_y_shift <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      rsr_pkg::REG_SIDE:           prdata = {21'd0, side_reg};
      rsr_pkg::REG_CENTER_X_SHIFT: prdata = {21'd0, center_x_shift};
      rsr_pkg::REG_CENTER_Y_SHIFT: prdata = {21'd0, center_y_shift};
      default:                     prdata = 32'd0;
    endcase
  end

  // stage enables, bubbles collapse
  logic en1, en2, en3, en4, en_o;
  logic v1, v2, v3, v4;

  assign en_o        = !blue_valid || !blue_stall;
  assign en4         = !v4 || en_o;
  assign en3         = !v3 || en4;
  assign pixel_stall = !en1;

  // stage 1: centre and absolute differences
  logic [10:0] side_eff;
  logic [9:0]  centre;
  logic [11:0] cx, cy;
  logic [12:0] dx, dy;
  logic [10:0] ax_next, ay_next;
  logic [10:0] ax, ay;

  always_comb begin
    side_eff = ({2'b00, side_reg} > 13'(MAX_SIDE)) ? 11'(MAX_SIDE) : side_reg;
    centre   = side_eff[10:1];
    cx       = {2'b00, centre} + {center_x_shift[10], center_x_shift};
    cy       = {2'b00, centre} + {center_y_shift[10], center_y_shift};
    dx       = {3'b000, pixel_x} - {cx[11], cx};
    dy       = {3'b000, pixel_y} - {cy[11], cy};
    ax_next  = dx[12] ? 11'(13'd0 - dx) : dx[10:0];
    ay_next  = dy[12] ? 11'(13'd0 - dy) : dy[10:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ax <= ax_next;
      ay <= ay_next;
    end
  end

  // stage 2: sum of squares
  logic [21:0] sqx, sqy;
  logic [22:0] sum_sq;

  assign sqx = {11'd0, ax} * {11'd0, ax};
  assign sqy = {11'd0, ay} * {11'd0, ay};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      sum_sq <= {1'b0, sqx} + {1'b0, sqy};
    end
  end

  // square root cell chain on sum_sq * 2^16
  rsr_pkg::sqrt_lane_t lane       [rsr_pkg::SQRT_CELLS+1];
  logic                lane_valid [rsr_pkg::SQRT_CELLS+1];
  logic                cell_en    [rsr_pkg::SQRT_CELLS+1];

  assign lane[0].rad  = {1'b0, sum_sq, 16'h0000};
  assign lane[0].rem  = '0;
  assign lane[0].root = '0;
  assign lane_valid[0] = v2;
  assign cell_en[rsr_pkg::SQRT_CELLS] = en3;
  assign en2 = !v2 || cell_en[0];
  assign en1 = !v1 || en2;

  for (genvar k = 0; k < rsr_pkg::SQRT_CELLS; k++) begin : g_cell
    assign cell_en[k] = !lane_valid[k+1] || cell_en[k+1];
    rsr_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (cell_en[k]),
      .in_valid  (lane_valid[k]),
      .in_lane   (lane[k]),
      .out_valid (lane_valid[k+1]),
      .out_lane  (lane[k+1])
    );
  end

  // stage 3: phase multiply, keep bits that form P mod 4*DEPTH
  logic [43:0]        prod;
  logic [IDX_W:0]     phase;

  assign prod = {24'd0, lane[rsr_pkg::SQRT_CELLS].root} * {20'd0, rsr_pkg::TWO_OVER_PI_Q24};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= lane_valid[rsr_pkg::SQRT_CELLS];
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      phase <= prod[33:32-DEPTH_LOG];
    end
  end

  // stage 4: quadrant folding
  logic [IDX_W-1:0] idx_next, idx;
  logic             neg;

  assign idx_next = phase[DEPTH_LOG]
                    ? IDX_W'(SINE_TABLE_DEPTH) - {1'b0, phase[DEPTH_LOG-1:0]}
                    : {1'b0, phase[DEPTH_LOG-1:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en4) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      idx <= idx_next;
      neg <= phase[DEPTH_LOG+1];
    end
  end

  // output stage: table read
  always_ff @(posedge clk) begin
    if (rst) begin
      blue_valid <= 1'b0;
    end else if (en_o) begin
      blue_valid <= v4;
    end
  end

  rsr_sine_lut #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_lut (
    .clk   (clk),
    .en    (en_o),
    .idx   (idx),
    .neg   (neg),
    .level (blue_level)
  );

endmodule

`default_nettype wire

FILE: hdl/rsr_checker.sv
// Port-level checks for radial_sine_ripple_pixel_top, attached by bind.
// Depends on rsr_pkg (PIPE_STAGES).
`default_nettype none

module rsr_checker (
  input logic       clk,
  input logic       rst,
  input logic       pixel_valid,
  input logic       pixel_stall,
  input logic       blue_valid,
  input logic       blue_stall,
  input logic [7:0] blue_level
);

  logic       in_acc, out_acc;
  logic [5:0] cnt;

  assign in_acc  = pixel_valid && !pixel_stall;
  assign out_acc = blue_valid && !blue_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 6'd0;
    end else begin
      cnt <= cnt + 6'(in_acc) - 6'(out_acc);
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !blue_valid)
    else $error("blue_valid set after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !blue_valid |-> !pixel_stall)
    else $error("input stalled with empty output");

  a_in_flight_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 6'(rsr_pkg::PIPE_STAGES))
    else $error("more transactions in flight than stages");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    blue_valid |-> cnt != 6'd0)
    else $error("result without a pending transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    blue_valid && blue_stall |=> blue_valid && $stable(blue_level))
    else $error("stalled result changed");

endmodule

bind radial_sine_ripple_pixel_top rsr_checker u_rsr_checker (.*);

`default_nettype wire

FILE: sim/tb_radial_sine_ripple_pixel_top.sv
// Self-checking testbench for radial_sine_ripple_pixel_top: pixel transactions in,
// blue levels out, each checked against a bit-exact predictor under random gaps/stalls.
// Depends on rsr_pkg (register indexes) and the block's RTL.
`default_nettype none

module tb_radial_sine_ripple_pixel_top;

  localparam logic [1:0]  REG_UNUSED  = 2'd3;
  localparam logic [63:0] SIDE_CAP    = 64'd1024;
  localparam logic [63:0] TAB_DEPTH   = 64'd256;
  localparam logic [63:0] Q30         = 64'd1073741824;
  localparam logic [63:0] HALF_PI     = 64'd1686629713;
  localparam logic [63:0] TWO_OVER_PI = 64'd10680707;
  localparam int          CYCLE_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        pixel_valid = 1'b0;
  logic        pixel_stall;
  logic [9:0]  pixel_x = '0;
  logic [9:0]  pixel_y = '0;
  logic        blue_valid;
  logic        blue_stall = 1'b0;
  logic [7:0]  blue_level;

  // predictor copy of the config registers
  logic [10:0] side_cfg = 11'd200;
  logic [10:0] shift_x_cfg = '0;
  logic [10:0] shift_y_cfg = '0;

  logic [7:0] pending_levels[$];
  bit         gaps_on = 1'b0;
  bit         stalls_on = 1'b0;
  int         errors = 0;
  int         n_pixels = 0;
  int         n_levels = 0;
  int         n_writes = 0;
  int         cycles = 0;

  radial_sine_ripple_pixel_top u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pixel_valid(pixel_valid), .pixel_stall(pixel_stall),
    .pixel_x(pixel_x), .pixel_y(pixel_y),
    .blue_valid(blue_valid), .blue_stall(blue_stall), .blue_level(blue_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // sin of table angle i in Q2.30, truncated Taylor series in Horner form
  function automatic logic [63:0] quarter_wave(input logic [63:0] i);
    logic [63:0] x, x2, t;
    x  = (i * HALF_PI) / TAB_DEPTH;
    x2 = (x * x) >> 30;
    t  = Q30;
    t  = Q30 - ((x2 * t) >> 30) / 64'd110;
    t  = Q30 - ((x2 * t) >> 30) / 64'd72;
    t  = Q30 - ((x2 * t) >> 30) / 64'd42;
    t  = Q30 - ((x2 * t) >> 30) / 64'd20;
    t  = Q30 - ((x2 * t) >> 30) / 64'd6;
    return (x * t) >> 30;
  endfunction

  function automatic logic [7:0] ripple_level(input logic [9:0] x, input logic [9:0] y);
    longint      ctr, dx, dy;
    logic [63:0] radius, phase, idx, mag, lvl;
    logic [1:0]  quad;
    ctr    = (64'(side_cfg) > SIDE_CAP) ? longint'(SIDE_CAP >> 1) : longint'(side_cfg >> 1);
    dx     = longint'(x) - (ctr + longint'(signed'(shift_x_cfg)));
    dy     = longint'(y) - (ctr + longint'(signed'(shift_y_cfg)));
    radius = floor_sqrt(64'(dx * dx + dy * dy) << 16);
    phase  = ((radius * TAB_DEPTH * TWO_OVER_PI) >> 32) % (64'd4 * TAB_DEPTH);
    quad   = 2'(phase / TAB_DEPTH);
    idx    = phase % TAB_DEPTH;
    mag    = quad[0] ? quarter_wave(TAB_DEPTH - idx) : quarter_wave(idx);
    if (mag > Q30) begin
      mag = Q30;
    end
    mag = quad[1] ? Q30 - mag : Q30 + mag;
    lvl = (mag * 64'd255) >> 31;
    if (lvl > 64'd255) begin
      lvl = 64'd255;
    end
    return lvl[7:0];
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t timeout: %0d levels still pending", $time, pending_levels.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // blue channel: random stall and result check
  always @(posedge clk) begin
    if (!rst && blue_valid && !blue_stall) begin
      if (pending_levels.size() == 0) begin
        $display("%0t unexpected blue transaction: expected none, got %0d", $time, blue_level);
        errors++;
      end else begin
        logic [7:0] want;
        want = pending_levels.pop_front();
        if (blue_level !== want) begin
          $display("%0t blue_level mismatch: expected %0d, got %0d", $time, want, blue_level);
          errors++;
        end
        n_levels++;
      end
    end
    blue_stall <= stalls_on && ($urandom_range(0, 99) < 23);
  end

  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
    while (gaps_on && $urandom_range(0, 99) < 23) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_x <= x;
    pixel_y <= y;
    do @(posedge clk); while (pixel_stall);
    pending_levels.push_back(ripple_level(x, y));
    n_pixels++;
  endtask

  task automatic drain_levels();
    pixel_valid <= 1'b0;
    do @(posedge clk); while (pending_levels.size() != 0);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      rsr_pkg::REG_SIDE:           side_cfg = data[10:0];
      rsr_pkg::REG_CENTER_X_SHIFT: shift_x_cfg = data[10:0];
      rsr_pkg::REG_CENTER_Y_SHIFT: shift_y_cfg = data[10:0];
      default: ;
    endcase
    n_writes++;
    @(posedge clk);
  endtask

  task automatic set_geometry(input logic [10:0] side, input logic [10:0] sx,
                              input logic [10:0] sy);
    drain_levels();
    write_reg(rsr_pkg::REG_SIDE, {21'd0, side});
    write_reg(rsr_pkg::REG_CENTER_X_SHIFT, {21'd0, sx});
    write_reg(rsr_pkg::REG_CENTER_Y_SHIFT, {21'd0, sy});
  endtask

  task automatic send_corners();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd0, 10'd1023);
    send_pixel(10'd1023, 10'd0);
  endtask

  task automatic test_reset_state();
    send_corners();
    send_pixel(10'd100, 10'd100);  // on the centre: zero distance
  endtask

  task automatic test_side_extremes();
    set_geometry(11'd0, 11'd0, 11'd0);        // centre at the shifts alone
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    set_geometry(11'd1, 11'd0, 11'd0);
    send_pixel(10'd1, 10'd0);
    set_geometry(11'd1024, 11'd0, 11'd0);
    send_pixel(10'd512, 10'd512);
    set_geometry(11'd2047, 11'd0, 11'd0);     // saturates to the max side
    send_pixel(10'd512, 10'd512);
    send_pixel(10'd0, 10'd0);
  endtask

  task automatic test_shift_extremes();
    set_geometry(11'd1024, 11'h400, 11'h3FF); // centre far outside the image
    send_corners();
    set_geometry(11'd0, 11'h3FF, 11'h400);
    send_corners();
  endtask

  task automatic test_unknown_register();
    drain_levels();
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(10'd300, 10'd700);
    send_pixel(10'd700, 10'd300);
  endtask

  task automatic random_pixels(input int count, input bit with_pause);
    logic [9:0] x, y;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 4) == 0) begin
        x = 10'($urandom_range(0, 31));
        y = 10'($urandom_range(0, 31));
      end else begin
        x = 10'($urandom);
        y = 10'($urandom);
      end
      send_pixel(x, y);
      if (with_pause && i == count / 2) begin
        drain_levels();
      end
    end
  endtask

  function automatic logic [10:0] pick_shift();
    case ($urandom_range(0, 5))
      0: return 11'h400;
      1: return 11'h3FF;
      2: return 11'h000;
      default: return 11'($urandom);
    endcase
  endfunction

  task automatic test_random_settings();
    logic [10:0] side;
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 5))
        0: side = 11'd0;
        1: side = 11'd1;
        2: side = 11'd1024;
        3: side = 11'd2047;
        default: side = 11'($urandom);
      endcase
      drain_levels();
      // junk in the upper data bits must be dropped
      write_reg(rsr_pkg::REG_SIDE, {21'($urandom), side});
      write_reg(rsr_pkg::REG_CENTER_X_SHIFT, {21'($urandom), pick_shift()});
      write_reg(rsr_pkg::REG_CENTER_Y_SHIFT, {21'($urandom), pick_shift()});
      random_pixels(220, ph == 1);
    end
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    stalls_on = 1'b0;
    set_geometry(11'd200, 11'd0, 11'd0);
    random_pixels(200, 1'b0);
    gaps_on = 1'b1;
    stalls_on = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    gaps_on = 1'b1;
    stalls_on = 1'b1;
    test_side_extremes();
    test_shift_extremes();
    test_unknown_register();
    test_random_settings();
    test_steady_stream();
    drain_levels();
    repeat (40) @(posedge clk);
    $display("Sent %0d pixels, checked %0d blue levels, %0d register writes", n_pixels,
             n_levels, n_writes);
    $display("Covered side and shift extremes, unused register, idle and stall mixes");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: radial_sine_ripple_pixel_top.f
hdl/rsr_pkg.sv
hdl/rsr_sqrt_cell.sv
hdl/rsr_sine_lut.sv
hdl/radial_sine_ripple_pixel_top.sv
hdl/rsr_checker.sv
sim/tb_radial_sine_ripple_pixel_top.sv
